>>> rtl/core/sand_cell_move_selector_unit_defines.svh
// assertion macros for the sand cell move selector
// taken in by the top level with an include of the bare file name
`ifndef SAND_CELL_MOVE_SELECTOR_UNIT_DEFINES_SVH
`define SAND_CELL_MOVE_SELECTOR_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SCMS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SCMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/scms_pkg.sv
// shared constants and tables for the sand cell move selector
// no dependencies; used by scms_rem_step and the top level
`default_nettype none

package scms_pkg;

   // neighbourhood geometry
   localparam int NEIGH_COUNT = 8;
   localparam int STEP_BITS   = 2;

   // tie-break random value, reduced one digit per pipeline stage
   localparam int RAND_BITS  = 16;
   localparam int DIGIT_BITS = 4;
   localparam int REM_STEPS  = RAND_BITS / DIGIT_BITS;

   // tie count is 0..8, remainder below the count is 0..7
   localparam int COUNT_BITS = 4;
   localparam int REM_BITS   = 3;
   localparam int WIDE_BITS  = REM_BITS + DIGIT_BITS;

   // result item layout
   localparam int RSP_DATA_BITS = 8;
   localparam int RSP_MOVED_BIT = 0;
   localparam int RSP_STEP_X_LSB = 1;
   localparam int RSP_STEP_Y_LSB = RSP_STEP_X_LSB + STEP_BITS;
   localparam int RSP_USED_BITS = RSP_STEP_Y_LSB + STEP_BITS;

   // offsets per neighbour, row-major with the centre skipped, two's complement
   localparam logic [STEP_BITS-1:0] OFF_X [NEIGH_COUNT] =
      '{2'b11, 2'b00, 2'b01, 2'b11, 2'b01, 2'b11, 2'b00, 2'b01};
   localparam logic [STEP_BITS-1:0] OFF_Y [NEIGH_COUNT] =
      '{2'b11, 2'b11, 2'b11, 2'b00, 2'b00, 2'b01, 2'b01, 2'b01};

endpackage

`default_nettype wire

>>> rtl/core/sand_cell_move_selector_unit.sv
// Sand cell move selector: takes one cell's 3x3 neighbourhood per item and returns
// whether the cell moves and its step (dx, dy). A direction is allowed when the
// neighbour exists, has a nonzero priority and is strictly less dense than the
// cell; the highest allowed priority wins and ties go to the (random mod count)-th
// tied neighbour in row-major order. The block takes one item every cycle while
// no stalled result backs up to its input, and returns each result through these
// stages: one stage for the allowed priorities, one for the maximum, one for the
// tie mask and count, four for the remainder (one 4-bit digit of the random
// value each) and one for the pick and the output register. A stalled result
// holds the pipeline only as far back as there are no empty stages to absorb it.
// depends on scms_pkg, scms_rem_step and sand_cell_move_selector_unit_defines.svh
`default_nettype none
`include "sand_cell_move_selector_unit_defines.svh"

module sand_cell_move_selector_unit #(
   parameter int PRIORITY_BITS = 4,
   parameter int DENSITY_BITS  = 8,
   localparam int PRIO_VEC_BITS  = scms_pkg::NEIGH_COUNT * PRIORITY_BITS,
   localparam int REQ_FIELD_BITS = PRIO_VEC_BITS + scms_pkg::NEIGH_COUNT
                                   + (scms_pkg::NEIGH_COUNT + 1) * DENSITY_BITS
                                   + scms_pkg::RAND_BITS,
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // direction_priorities, neighbour_present, own_density, density_up_left,
   // density_up, density_up_right, density_left, density_right,
   // density_down_left, density_down, density_down_right, random_value
   input  logic [REQ_DATA_BITS-1:0]             req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // moved, step_x, step_y
   output logic [scms_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);

   localparam int NC         = scms_pkg::NEIGH_COUNT;
   localparam int STEPS      = scms_pkg::REM_STEPS;
   localparam int STAGES     = STEPS + 4;
   localparam int PRESENT_LSB = PRIO_VEC_BITS;
   localparam int OWN_LSB    = PRESENT_LSB + NC;
   localparam int DENS_LSB   = OWN_LSB + DENSITY_BITS;
   localparam int RAND_LSB   = DENS_LSB + NC * DENSITY_BITS;
   localparam int ST_ELIG    = 0;
   localparam int ST_BEST    = 1;
   localparam int ST_MASK    = 2;
   localparam int ST_REM     = 3;
   localparam int ST_OUT     = STAGES - 1;

   // pipeline control
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] go;

   // stage payloads
   logic [PRIORITY_BITS-1:0]           prio_ff [NC];
   logic [PRIORITY_BITS-1:0]           prio_in [NC];
   logic [scms_pkg::RAND_BITS-1:0]     rnd_elig_ff;
   logic [PRIORITY_BITS-1:0]           prio_best_ff [NC];
   logic [PRIORITY_BITS-1:0]           best_ff;
   logic [PRIORITY_BITS-1:0]           best_in;
   logic [scms_pkg::RAND_BITS-1:0]     rnd_best_ff;
   logic [NC-1:0]                      mask_in;
   logic [scms_pkg::COUNT_BITS-1:0]    count_in;
   logic [NC-1:0]                      mask_ff  [STEPS+1];
   logic [scms_pkg::COUNT_BITS-1:0]    count_ff [STEPS+1];
   logic [scms_pkg::RAND_BITS-1:0]     rnd_ff   [STEPS];
   logic [scms_pkg::REM_BITS-1:0]      rem_q    [STEPS+1];
   logic [NC-1:0]                      sel;
   logic                               moved_in;
   logic [scms_pkg::STEP_BITS-1:0]     step_x_in;
   logic [scms_pkg::STEP_BITS-1:0]     step_y_in;
   logic                               moved_ff;
   logic [scms_pkg::STEP_BITS-1:0]     step_x_ff;
   logic [scms_pkg::STEP_BITS-1:0]     step_y_ff;

   // a stage loads when it is empty or its content moves on
   assign go[ST_OUT] = !valid_ff[ST_OUT] || rsp_tready;
   for (genvar s = 0; s < ST_OUT; s++) begin : g_go
      assign go[s] = !valid_ff[s] || go[s+1];
   end

   assign req_tready = go[ST_ELIG];

   always_comb begin
      for (int s = 0; s < STAGES; s++) begin
         if (!go[s]) begin
            valid_in[s] = valid_ff[s];
         end else if (s == 0) begin
            valid_in[s] = req_tvalid;
         end else begin
            valid_in[s] = valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage 0: priority of each neighbour that is present and lighter, else zero
   always_comb begin
      logic [DENSITY_BITS-1:0] own;
      logic [DENSITY_BITS-1:0] dens;
      own = req_tdata[OWN_LSB +: DENSITY_BITS];
      for (int i = 0; i < NC; i++) begin
         dens = req_tdata[DENS_LSB + i * DENSITY_BITS +: DENSITY_BITS];
         if (req_tdata[PRESENT_LSB + i] && (dens < own)) begin
            prio_in[i] = req_tdata[i * PRIORITY_BITS +: PRIORITY_BITS];
         end else begin
            prio_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go[ST_ELIG]) begin
         prio_ff     <= prio_in;
         rnd_elig_ff <= req_tdata[RAND_LSB +: scms_pkg::RAND_BITS];
      end
   end

   // stage 1: maximum priority through a three-level compare tree
   always_comb begin
      logic [PRIORITY_BITS-1:0] lvl1 [NC/2];
      logic [PRIORITY_BITS-1:0] lvl2 [NC/4];
      for (int i = 0; i < NC / 2; i++) begin
         lvl1[i] = (prio_ff[2*i] > prio_ff[2*i+1]) ? prio_ff[2*i] : prio_ff[2*i+1];
      end
      for (int i = 0; i < NC / 4; i++) begin
         lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
      end
      best_in = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
   end

   always_ff @(posedge clock) begin
      if (go[ST_BEST]) begin
         prio_best_ff <= prio_ff;
         best_ff      <= best_in;
         rnd_best_ff  <= rnd_elig_ff;
      end
   end

   // stage 2: tied directions and how many there are
   always_comb begin
      count_in = '0;
      for (int i = 0; i < NC; i++) begin
         mask_in[i] = (prio_best_ff[i] == best_ff) && (best_ff != '0);
         count_in   = count_in + scms_pkg::COUNT_BITS'(mask_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (go[ST_MASK]) begin
         mask_ff[0]  <= mask_in;
         count_ff[0] <= count_in;
         rnd_ff[0]   <= rnd_best_ff;
      end
   end

   // stages 3 to 6: random value mod tie count, most significant digit first
   assign rem_q[0] = '0;

   for (genvar k = 0; k < STEPS; k++) begin : g_rem
      scms_rem_step u_rem_step (
         .clock    (clock),
         .load     (go[ST_REM + k]),
         .divisor  (count_ff[k]),
         .rem_prev (rem_q[k]),
         .digit    (rnd_ff[k][scms_pkg::RAND_BITS - 1 - k * scms_pkg::DIGIT_BITS
                              -: scms_pkg::DIGIT_BITS]),
         .rem      (rem_q[k+1])
      );

      always_ff @(posedge clock) begin
         if (go[ST_REM + k]) begin
            mask_ff[k+1]  <= mask_ff[k];
            count_ff[k+1] <= count_ff[k];
         end
      end

      // the random value is only needed up to the last digit step
      if (k + 1 < STEPS) begin : g_rnd
         always_ff @(posedge clock) begin
            if (go[ST_REM + k]) begin
               rnd_ff[k+1] <= rnd_ff[k];
            end
         end
      end
   end

   // stage 7: pick the tied direction whose rank equals the remainder
   always_comb begin
      logic [scms_pkg::COUNT_BITS-1:0] rank;
      step_x_in = '0;
      step_y_in = '0;
      for (int i = 0; i < NC; i++) begin
         rank = '0;
         for (int j = 0; j < NC; j++) begin
            if (j < i) begin
               rank = rank + scms_pkg::COUNT_BITS'(mask_ff[STEPS][j]);
            end
         end
         sel[i] = mask_ff[STEPS][i]
                  && (rank == scms_pkg::COUNT_BITS'(rem_q[STEPS]));
         if (sel[i]) begin
            step_x_in = step_x_in | scms_pkg::OFF_X[i];
            step_y_in = step_y_in | scms_pkg::OFF_Y[i];
         end
      end
      moved_in = |mask_ff[STEPS];
   end

   always_ff @(posedge clock) begin
      if (go[ST_OUT]) begin
         moved_ff  <= moved_in;
         step_x_ff <= step_x_in;
         step_y_ff <= step_y_in;
      end
   end

   // result item
   assign rsp_tvalid = valid_ff[ST_OUT];
   assign rsp_tdata  = {(scms_pkg::RSP_DATA_BITS - scms_pkg::RSP_USED_BITS)'(0),
                        step_y_ff, step_x_ff, moved_ff};

   // checks
   `SCMS_ASSERT_NOW(a_count_matches_mask, clock, reset, valid_ff[ST_MASK],
      count_ff[0] == scms_pkg::COUNT_BITS'($countones(mask_ff[0])),
      "tie count differs from the tie mask")
   `SCMS_ASSERT_NOW(a_rem_below_count, clock, reset,
      valid_ff[ST_OUT-1] && (count_ff[STEPS] != '0),
      scms_pkg::COUNT_BITS'(rem_q[STEPS]) < count_ff[STEPS],
      "tie-break remainder not below the tie count")
   `SCMS_ASSERT_NOW(a_single_pick, clock, reset,
      valid_ff[ST_OUT-1] && (mask_ff[STEPS] != '0), $onehot(sel),
      "tied directions present but not exactly one picked")
   `SCMS_ASSERT_NEXT(a_result_loaded, clock, reset,
      valid_ff[ST_OUT-1] && go[ST_OUT], rsp_tvalid,
      "item left the last remainder stage but no result shown")

endmodule

`default_nettype wire

>>> rtl/core/scms_rem_step.sv
// one digit step of the tie-break remainder: (rem * 16 + digit) mod divisor
// depends on scms_pkg for the digit and remainder widths
`default_nettype none

module scms_rem_step (
   input  logic                                 clock,
   input  logic                                 load,
   input  logic [scms_pkg::COUNT_BITS-1:0]      divisor,
   input  logic [scms_pkg::REM_BITS-1:0]        rem_prev,
   input  logic [scms_pkg::DIGIT_BITS-1:0]      digit,
   output logic [scms_pkg::REM_BITS-1:0]        rem
);

   logic [scms_pkg::REM_BITS-1:0] rem_ff;
   logic [scms_pkg::REM_BITS-1:0] rem_in;

   // restoring long division of the partial value by the tie count
   always_comb begin
      logic [scms_pkg::WIDE_BITS-1:0] wide;
      logic [scms_pkg::WIDE_BITS-1:0] trial;
      wide = {rem_prev, digit};
      for (int k = scms_pkg::DIGIT_BITS - 1; k >= 0; k--) begin
         trial = scms_pkg::WIDE_BITS'(divisor) << k;
         if (wide >= trial) begin
            wide = wide - trial;
         end
      end
      rem_in = wide[scms_pkg::REM_BITS-1:0];
   end

   // stage register, advances with the pipeline
   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= rem_in;
      end
   end

   assign rem = rem_ff;

endmodule

`default_nettype wire

>>> tb/sv/move_choice_checker.sv
`timescale 1ns / 1ps
// checker for the sand cell move selector: watches both streams, predicts each move
// and compares it with the block's result; standalone, needs no package
module move_choice_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // direction_priorities, neighbour_present, own_density, eight neighbour
   // densities (up_left first), random_value
   input  logic [127:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // moved, step_x, step_y
   input  logic [7:0]   rsp_tdata,
   output int           failures,
   output int           open_results
);

   // one cell's neighbourhood as packed on req_tdata, lowest field last
   typedef struct packed {
      logic [15:0]      random_value;
      logic [7:0][7:0]  density;
      logic [7:0]       own_density;
      logic [7:0]       neighbour_present;
      logic [7:0][3:0]  dir_prio;
   } cell_view_type;

   // one move as packed on rsp_tdata
   typedef struct packed {
      logic [2:0]        pad;
      logic signed [1:0] step_y;
      logic signed [1:0] step_x;
      logic              moved;
   } move_type;

   move_type expected_moves [$];
   int       results_seen = 0;

   // highest allowed priority wins, ties resolved by random value mod tie count
   function automatic move_type choose_move(input cell_view_type c);
      logic [3:0] allowed [8];
      logic [3:0] best;
      int         tied;
      int         pick;
      int         seen;
      int         pos;
      int         dx;
      int         dy;
      move_type   m;
      best = '0;
      tied = 0;
      seen = 0;
      m    = '0;
      for (int i = 0; i < 8; i++) begin
         allowed[i] = (c.neighbour_present[i] && c.density[i] < c.own_density)
                      ? c.dir_prio[i] : 4'd0;
         if (allowed[i] > best) best = allowed[i];
      end
      if (best == 0) return m;
      for (int i = 0; i < 8; i++)
         if (allowed[i] == best) tied++;
      pick = int'(c.random_value) % tied;
      for (int i = 0; i < 8; i++) begin
         if (allowed[i] == best) begin
            if (seen == pick) begin
               // position in the 3x3 grid with the centre skipped
               pos = (i < 4) ? i : i + 1;
               dx  = pos % 3 - 1;
               dy  = pos / 3 - 1;
               m.moved  = 1'b1;
               m.step_x = dx[1:0];
               m.step_y = dy[1:0];
               return m;
            end
            seen++;
         end
      end
      return m;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
      failures++;
   endtask

   initial begin
      failures     = 0;
      open_results = 0;
   end

   // compare finished moves first, then record new cells
   always @(posedge clock) begin
      move_type got;
      move_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = move_type'(rsp_tdata);
            if (expected_moves.size() == 0) begin
               flag_mismatch($sformatf("unexpected item %h", rsp_tdata));
            end else begin
               want = expected_moves.pop_front();
               if (got.moved !== want.moved)
                  flag_mismatch($sformatf("moved %b, expected %b", got.moved, want.moved));
               if (got.step_x !== want.step_x)
                  flag_mismatch($sformatf("step_x %b, expected %b", got.step_x, want.step_x));
               if (got.step_y !== want.step_y)
                  flag_mismatch($sformatf("step_y %b, expected %b", got.step_y, want.step_y));
            end
            results_seen++;
         end
         if (req_tvalid && req_tready)
            expected_moves.push_back(choose_move(cell_view_type'(req_tdata)));
         open_results = expected_moves.size();
      end
   end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// top of the sand cell move selector testbench: clock, reset, cell stimulus and verdict
// depends on scms_pkg, sand_cell_move_selector_unit and move_choice_checker
module testbench;

   localparam int CELL_BITS = 128;

   logic                                clock;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [CELL_BITS-1:0]                req_tdata  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [scms_pkg::RSP_DATA_BITS-1:0]  rsp_tdata;

   int failures;
   int open_results;
   int idle_pct      = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int hold_served   = 0;

   sand_cell_move_selector_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   move_choice_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .failures     (failures),
      .open_results (open_results)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("sand_cell_move_selector_unit verification failed");
      $finish;
   end

   // result side: random stalls, plus long hold-offs on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served++;
            rsp_tready <= 1'b0;
            repeat (48) @(negedge clock);
         end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [CELL_BITS-1:0] pack_cell(
      input logic [7:0][3:0] prio,
      input logic [7:0]      present,
      input logic [7:0]      own,
      input logic [7:0][7:0] dens,
      input logic [15:0]     rnd
   );
      return {rnd, dens, own, present, prio};
   endfunction

   // mostly well-formed neighbourhoods with ties and near-equal densities
   function automatic logic [CELL_BITS-1:0] random_cell();
      logic [7:0][3:0] prio;
      logic [7:0][7:0] dens;
      logic [7:0]      own;
      logic [7:0]      present;
      logic [3:0]      level;
      int              style;
      style = $urandom_range(3);
      if (style == 0) return {$urandom, $urandom, $urandom, $urandom};
      own     = 8'($urandom);
      level   = 4'($urandom_range(1, 15));
      present = (style == 1) ? 8'($urandom | $urandom) : 8'($urandom);
      for (int i = 0; i < 8; i++) begin
         case ($urandom_range(3))
            0:       prio[i] = 4'd0;
            1, 2:    prio[i] = level;
            default: prio[i] = 4'($urandom);
         endcase
         case ($urandom_range(3))
            0:       dens[i] = (own == 0) ? 8'd0 : 8'($urandom_range(int'(own) - 1));
            1:       dens[i] = own;
            2:       dens[i] = 8'($urandom_range(int'(own), 255));
            default: dens[i] = 8'($urandom);
         endcase
      end
      return pack_cell(prio, present, own, dens, 16'($urandom));
   endfunction

   // offer one cell from a falling edge, with a random idle gap first
   task automatic offer_cell(input logic [CELL_BITS-1:0] item_bits);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= item_bits;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // stop offering and wait for every expected move
   task automatic drain_moves();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (open_results == 0);
      @(negedge clock);
   endtask

   task automatic random_burst(input int count);
      repeat (count) offer_cell(random_cell());
   endtask

   // stimulus
   initial begin
      logic [7:0][3:0] prio;
      logic [7:0][7:0] dens;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty item, full eight-way ties, corner random values
      offer_cell('0);
      prio = {8{4'hf}};
      dens = '0;
      offer_cell(pack_cell(prio, 8'hff, 8'hff, dens, 16'd0));
      offer_cell(pack_cell(prio, 8'hff, 8'hff, dens, 16'd7));
      offer_cell(pack_cell(prio, 8'hff, 8'hff, dens, 16'd13));
      offer_cell(pack_cell(prio, 8'hff, 8'hff, dens, 16'hffff));
      // equal and heavier neighbours never allow a move
      offer_cell(pack_cell(prio, 8'hff, 8'd100, {8{8'd100}}, 16'd3));
      offer_cell(pack_cell(prio, 8'hff, 8'd100, {8{8'd200}}, 16'd3));
      // zero priorities, no neighbours, and a weightless cell
      offer_cell(pack_cell('0, 8'hff, 8'hff, dens, 16'd5));
      offer_cell(pack_cell(prio, 8'h00, 8'hff, dens, 16'd5));
      offer_cell(pack_cell(prio, 8'hff, 8'h00, dens, 16'd5));
      // each direction on its own
      for (int i = 0; i < 8; i++)
         offer_cell(pack_cell(prio, 8'(1 << i), 8'h80, {8{8'h7f}}, 16'($urandom)));
      // distinct priorities, the highest wins
      prio = {4'd3, 4'd9, 4'd1, 4'd12, 4'd4, 4'd11, 4'd2, 4'd7};
      offer_cell(pack_cell(prio, 8'hff, 8'h40, {8{8'h3f}}, 16'hffff));
      // three-way tie on the top priority
      prio = {4'd6, 4'd2, 4'd6, 4'd1, 4'd5, 4'd6, 4'd0, 4'd3};
      offer_cell(pack_cell(prio, 8'hff, 8'h40, {8{8'h10}}, 16'hffff));
      offer_cell(pack_cell(prio, 8'hff, 8'h40, {8{8'h10}}, 16'd4));

      // long hold-off on the result side while cells keep coming
      hold_requests++;
      random_burst(30);
      drain_moves();

      // no idling
      random_burst(200);
      drain_moves();

      // sender idle most of the time
      idle_pct  = 63;
      stall_pct = 0;
      random_burst(200);
      drain_moves();

      // receiver stalling most of the time
      idle_pct  = 0;
      stall_pct = 63;
      random_burst(200);
      drain_moves();

      // light idling on both sides
      idle_pct  = 9;
      stall_pct = 9;
      random_burst(220);
      drain_moves();

      repeat (16) @(posedge clock);
      if (failures == 0 && open_results == 0) begin
         $display("sand_cell_move_selector_unit verification clean");
      end else begin
         $display("sand_cell_move_selector_unit verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/scms_pkg.sv
rtl/core/scms_rem_step.sv
rtl/core/sand_cell_move_selector_unit.sv
tb/sv/move_choice_checker.sv
tb/sv/testbench.sv
